>>> rtl/core/iprt_pkg.sv
// Shared types and codes for the IPv4 fragment reassembly tracker.
// Used by ip_fragment_reassembly_tracker; depends on nothing else.
package iprt_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QRD,
    S_QEV,
    S_TRIM,
    S_RRD,
    S_REV,
    S_CHECK,
    S_MRD,
    S_MEV,
    S_INS,
    S_CRD,
    S_CEV,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    KIND_DGRAM   = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_DRAIN   = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    STAT_PASSED   = 3'd0,
    STAT_HELD     = 3'd1,
    STAT_COVERED  = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_COMPLETE = 3'd4,
    STAT_TICK     = 3'd5,
    STAT_DRAIN    = 3'd6
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [2:0]  slot;
    logic [16:0] kept_offset;
    logic [16:0] kept_length;
    logic [4:0]  removed;
    logic [15:0] next_trim;
    logic [16:0] total;
    logic [3:0]  expired;
  } result_t;

  typedef struct packed {
    logic [16:0] start;
    logic [16:0] size;
    logic        more;
  } seg_t;

  localparam logic [7:0] LifetimeReset = 8'd15;

endpackage

>>> rtl/core/ip_fragment_reassembly_tracker.sv
// Top level of the IPv4 fragment reassembly tracker: context table and the
// sequencer around the segment memory. Depends on iprt_pkg.
//
// Usage: requests enter on in_valid_i/in_stall_o, one per accepted edge.
// A request is a fragment or datagram, a timer tick, or a drain of all
// contexts. Each request except kind 3 yields one result on
// out_valid_o/out_stall_i. A result waits in an output register, so the
// next request is accepted while the receiver stalls; a finished result
// that finds the register still full waits in its final state.
// Ticks, drains, unfragmented datagrams and fragments refused for lack of
// a free context go from idle straight to the final state. A fragment
// walks its context's segments in the segment memory, which has one read
// and one write port: a search pass up to the insertion point, an overlap
// pass, a move pass and a contiguity pass.
// The fragment_lifetime register is written on cfg_valid_i and always
// ready; write it only while the block is idle.
// Reset clears all contexts, sets the lifetime to 15 and empties the
// output register. The segment memory needs no clearing pass.
module ip_fragment_reassembly_tracker #(
  parameter int CONTEXTS = 8,
  parameter int SEGMENTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] ident_i,
  input  logic [7:0]  protocol_i,
  input  logic [12:0] frag_offset_i,
  input  logic [15:0] payload_len_i,
  input  logic        more_frags_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [2:0]  context_slot_o,
  output logic [16:0] kept_offset_o,
  output logic [16:0] kept_length_o,
  output logic [4:0]  removed_segments_o,
  output logic [15:0] next_trim_o,
  output logic [16:0] total_length_o,
  output logic [3:0]  expired_count_o
);
  import iprt_pkg::*;

  localparam int CIW   = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int CNW   = $clog2(CONTEXTS + 1);
  localparam int SIW   = $clog2(SEGMENTS);
  localparam int SCW   = $clog2(SEGMENTS + 1);
  localparam int DEPTH = CONTEXTS * SEGMENTS;
  localparam int AW    = $clog2(DEPTH);

  // Context table.
  logic             ctx_valid_q [CONTEXTS];
  logic [31:0]      ctx_src_q   [CONTEXTS];
  logic [31:0]      ctx_dst_q   [CONTEXTS];
  logic [15:0]      ctx_id_q    [CONTEXTS];
  logic [7:0]       ctx_prot_q  [CONTEXTS];
  logic [7:0]       ctx_age_q   [CONTEXTS];
  logic [SCW-1:0]   seg_cnt_q   [CONTEXTS];

  // Segment memory.
  seg_t             seg_mem [DEPTH];
  seg_t             rd_q;
  logic             mem_we;
  logic [AW-1:0]    mem_wa, mem_ra;
  seg_t             mem_wd;

  state_e           state_q, state_d;
  logic [CIW-1:0]   slot_q, slot_d;
  logic [SCW-1:0]   cnt_q, cnt_d, k_q, k_d, q_q, q_d, r_q, r_d, m_q, m_d;
  logic [17:0]      off_q, off_d, len_q, len_d, end_q, end_d;
  logic [17:0]      prev_end_q, prev_end_d, trim_q, trim_d, next_q, next_d;
  logic             mf_q, mf_d, last_more_q, last_more_d;
  result_t          res_q, res_d, out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       lifetime_q, lifetime_d;

  logic             in_fire, unfrag, alloc, rel_done;
  logic [CONTEXTS-1:0] hit_vec, kill_vec, valid_vec;
  logic             hit_any, free_any;
  logic [CIW-1:0]   hit_idx, free_idx;
  logic [CNW-1:0]   tick_n, drain_n;
  logic [17:0]      off_in, len_in;

  function automatic logic [AW-1:0] seg_addr(input logic [CIW-1:0] s,
                                             input logic [SCW-1:0] i);
    return AW'(AW'(s) * AW'(SEGMENTS)) + AW'(i[SIW-1:0]);
  endfunction

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && (state_q == S_IDLE);
  assign off_in      = {2'b00, frag_offset_i, 3'b000};
  assign len_in      = {2'b00, payload_len_i};
  assign unfrag      = !more_frags_i && (frag_offset_i == 13'd0);

  // Key match, free slot search, tick expiry and drain count over all contexts.
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    tick_n   = '0;
    drain_n  = '0;
    for (int c = 0; c < CONTEXTS; c++) begin
      hit_vec[c]   = ctx_valid_q[c] && (ctx_src_q[c] == src_addr_i) &&
                     (ctx_dst_q[c] == dst_addr_i) && (ctx_id_q[c] == ident_i) &&
                     (ctx_prot_q[c] == protocol_i);
      kill_vec[c]  = ctx_valid_q[c] && (ctx_age_q[c] == 8'd1);
      valid_vec[c] = ctx_valid_q[c];
      tick_n       = tick_n + CNW'(kill_vec[c]);
      drain_n      = drain_n + CNW'(valid_vec[c]);
    end
    for (int c = CONTEXTS - 1; c >= 0; c--) begin
      if (hit_vec[c]) begin
        hit_any = 1'b1;
        hit_idx = CIW'(c);
      end
      if (!valid_vec[c]) begin
        free_any = 1'b1;
        free_idx = CIW'(c);
      end
    end
  end

  assign alloc    = in_fire && (kind_i == KIND_DGRAM) && !unfrag && !hit_any && free_any;
  assign rel_done = (state_q == S_CRD) && (k_q == cnt_q) && !last_more_q;

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    q_d         = q_q;
    r_d         = r_q;
    m_d         = m_q;
    off_d       = off_q;
    len_d       = len_q;
    end_d       = end_q;
    prev_end_d  = prev_end_q;
    trim_d      = trim_q;
    next_d      = next_q;
    mf_d        = mf_q;
    last_more_d = last_more_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    lifetime_d  = lifetime_q;
    mem_we      = 1'b0;
    mem_wa      = seg_addr(slot_q, m_q);
    mem_wd      = rd_q;
    mem_ra      = seg_addr(slot_q, k_q);

    if (cfg_valid_i) begin
      lifetime_d = cfg_data_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_d = '0;
          case (kind_i)
            KIND_TICK: begin
              res_d.status  = STAT_TICK;
              res_d.expired = 4'(tick_n);
              state_d       = S_DONE;
            end
            KIND_DRAIN: begin
              res_d.status  = STAT_DRAIN;
              res_d.expired = 4'(drain_n);
              state_d       = S_DONE;
            end
            KIND_DGRAM: begin
              off_d = off_in;
              len_d = len_in;
              end_d = off_in + len_in;
              mf_d  = more_frags_i;
              if (unfrag) begin
                res_d.status = STAT_PASSED;
                res_d.slot   = hit_any ? 3'(hit_idx) : 3'd0;
                state_d      = S_DONE;
              end else if (!hit_any && !free_any) begin
                res_d.status = STAT_FULL;
                state_d      = S_DONE;
              end else begin
                slot_d     = hit_any ? hit_idx : free_idx;
                cnt_d      = hit_any ? seg_cnt_q[hit_idx] : '0;
                k_d        = '0;
                prev_end_d = '0;
                state_d    = S_QRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_QRD: begin
        if (k_q == cnt_q) begin
          q_d     = k_q;
          state_d = S_TRIM;
        end else begin
          state_d = S_QEV;
        end
      end
      S_QEV: begin
        if ({1'b0, rd_q.start} > off_q) begin
          q_d     = k_q;
          state_d = S_TRIM;
        end else begin
          prev_end_d = {1'b0, rd_q.start} + {1'b0, rd_q.size};
          k_d        = k_q + SCW'(1);
          state_d    = S_QRD;
        end
      end
      S_TRIM: begin
        k_d     = q_q;
        r_d     = '0;
        trim_d  = '0;
        state_d = S_RRD;
        // The preceding segment overlaps the front of the fragment.
        if ((q_q != '0) && (prev_end_q > off_q)) begin
          if (prev_end_q - off_q >= len_q) begin
            res_d.status = STAT_COVERED;
            res_d.slot   = 3'(slot_q);
            state_d      = S_DONE;
          end else begin
            off_d = prev_end_q;
            len_d = end_q - prev_end_q;
          end
        end
      end
      S_RRD: begin
        state_d = (k_q == cnt_q) ? S_CHECK : S_REV;
      end
      S_REV: begin
        if (end_q <= {1'b0, rd_q.start}) begin
          state_d = S_CHECK;
        end else if (end_q - {1'b0, rd_q.start} < {1'b0, rd_q.size}) begin
          trim_d  = end_q - {1'b0, rd_q.start};
          state_d = S_CHECK;
        end else begin
          r_d     = r_q + SCW'(1);
          k_d     = k_q + SCW'(1);
          state_d = S_RRD;
        end
      end
      S_CHECK: begin
        if (cnt_q - r_q >= SCW'(SEGMENTS)) begin
          res_d.status = STAT_FULL;
          res_d.slot   = 3'(slot_q);
          state_d      = S_DONE;
        end else if (r_q == '0) begin
          // Open a gap: move the tail up by one, from the top down.
          if (cnt_q == q_q) begin
            state_d = S_INS;
          end else begin
            m_d     = cnt_q - SCW'(1);
            state_d = S_MRD;
          end
        end else begin
          // Close over removed segments: move the tail down, bottom up.
          if (q_q + r_q == cnt_q) begin
            state_d = S_INS;
          end else begin
            m_d     = q_q + r_q;
            state_d = S_MRD;
          end
        end
      end
      S_MRD: begin
        mem_ra  = seg_addr(slot_q, m_q);
        state_d = S_MEV;
      end
      S_MEV: begin
        mem_we = 1'b1;
        mem_wa = seg_addr(slot_q, SCW'(m_q + SCW'(1) - r_q));
        if (m_q == q_q + r_q) begin
          mem_wd.start = rd_q.start + trim_q[16:0];
          mem_wd.size  = rd_q.size - trim_q[16:0];
        end
        if (r_q == '0) begin
          if (m_q == q_q) begin
            state_d = S_INS;
          end else begin
            m_d = m_q - SCW'(1);
          end
        end else begin
          if (m_q == cnt_q - SCW'(1)) begin
            state_d = S_INS;
          end else begin
            m_d = m_q + SCW'(1);
          end
        end
        if (state_d != S_INS) begin
          state_d = S_MRD;
        end
      end
      S_INS: begin
        mem_we             = 1'b1;
        mem_wa             = seg_addr(slot_q, q_q);
        mem_wd             = '{start: off_q[16:0], size: len_q[16:0], more: mf_q};
        cnt_d              = cnt_q - r_q + SCW'(1);
        k_d                = '0;
        next_d             = '0;
        res_d.status       = STAT_HELD;
        res_d.slot         = 3'(slot_q);
        res_d.kept_offset  = off_q[16:0];
        res_d.kept_length  = len_q[16:0];
        res_d.removed      = 5'(r_q);
        res_d.next_trim    = trim_q[15:0];
        state_d            = S_CRD;
      end
      S_CRD: begin
        if (k_q == cnt_q) begin
          if (!last_more_q) begin
            res_d.status = STAT_COMPLETE;
            res_d.total  = next_q[16:0];
          end
          state_d = S_DONE;
        end else begin
          state_d = S_CEV;
        end
      end
      S_CEV: begin
        if ({1'b0, rd_q.start} != next_q) begin
          state_d = S_DONE;
        end else begin
          next_d      = next_q + {1'b0, rd_q.size};
          last_more_d = rd_q.more;
          k_d         = k_q + SCW'(1);
          state_d     = S_CRD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      lifetime_q  <= LifetimeReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      lifetime_q  <= lifetime_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    cnt_q       <= cnt_d;
    k_q         <= k_d;
    q_q         <= q_d;
    r_q         <= r_d;
    m_q         <= m_d;
    off_q       <= off_d;
    len_q       <= len_d;
    end_q       <= end_d;
    prev_end_q  <= prev_end_d;
    trim_q      <= trim_d;
    next_q      <= next_d;
    mf_q        <= mf_d;
    last_more_q <= last_more_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  // Context valid bits and segment counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CONTEXTS; c++) begin
        ctx_valid_q[c] <= 1'b0;
        seg_cnt_q[c]   <= '0;
      end
    end else begin
      if (in_fire) begin
        case (kind_i)
          KIND_TICK: begin
            for (int c = 0; c < CONTEXTS; c++) begin
              if (kill_vec[c]) begin
                ctx_valid_q[c] <= 1'b0;
                seg_cnt_q[c]   <= '0;
              end
            end
          end
          KIND_DRAIN: begin
            for (int c = 0; c < CONTEXTS; c++) begin
              ctx_valid_q[c] <= 1'b0;
              seg_cnt_q[c]   <= '0;
            end
          end
          KIND_DGRAM: begin
            if (unfrag && hit_any) begin
              ctx_valid_q[hit_idx] <= 1'b0;
              seg_cnt_q[hit_idx]   <= '0;
            end else if (alloc) begin
              ctx_valid_q[free_idx] <= 1'b1;
              seg_cnt_q[free_idx]   <= '0;
            end
          end
          default: ;
        endcase
      end
      if (state_q == S_INS) begin
        seg_cnt_q[slot_q] <= cnt_q - r_q + SCW'(1);
      end
      if (rel_done) begin
        ctx_valid_q[slot_q] <= 1'b0;
        seg_cnt_q[slot_q]   <= '0;
      end
    end
  end

  // Context keys and ages.
  always_ff @(posedge clk_i) begin
    if (in_fire && (kind_i == KIND_TICK)) begin
      for (int c = 0; c < CONTEXTS; c++) begin
        if (ctx_valid_q[c]) begin
          ctx_age_q[c] <= ctx_age_q[c] - 8'd1;
        end
      end
    end
    if (alloc) begin
      ctx_src_q[free_idx]  <= src_addr_i;
      ctx_dst_q[free_idx]  <= dst_addr_i;
      ctx_id_q[free_idx]   <= ident_i;
      ctx_prot_q[free_idx] <= protocol_i;
      ctx_age_q[free_idx]  <= lifetime_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seg_mem[mem_wa] <= mem_wd;
    end
    rd_q <= seg_mem[mem_ra];
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_q.status;
  assign context_slot_o     = out_q.slot;
  assign kept_offset_o      = out_q.kept_offset;
  assign kept_length_o      = out_q.kept_length;
  assign removed_segments_o = out_q.removed;
  assign next_trim_o        = out_q.next_trim;
  assign total_length_o     = out_q.total;
  assign expired_count_o    = out_q.expired;

endmodule

>>> sim/tb.sv
// Self-checking testbench for ip_fragment_reassembly_tracker: drives fragments, ticks and
// drains, predicts each result with a behavioral tracker model and compares field by field.
// Depends on iprt_pkg and the tracker RTL.
module tb;
  import iprt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCTX = 8;
  localparam int NSEG = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    kind_e       kind;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] ident;
    logic [7:0]  proto;
    logic [12:0] offset;
    logic [15:0] len;
    logic        mf;
  } request_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [7:0] cfg_data;
  logic in_valid, in_stall;
  request_t cur;
  logic out_valid, out_stall;
  logic [2:0] status, slot;
  logic [16:0] kept_off, kept_len, total;
  logic [4:0] removed;
  logic [15:0] next_trim;
  logic [3:0] expired;

  ip_fragment_reassembly_tracker u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(cur.kind), .src_addr_i(cur.src), .dst_addr_i(cur.dst),
    .ident_i(cur.ident), .protocol_i(cur.proto), .frag_offset_i(cur.offset),
    .payload_len_i(cur.len), .more_frags_i(cur.mf),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .context_slot_o(slot), .kept_offset_o(kept_off),
    .kept_length_o(kept_len), .removed_segments_o(removed), .next_trim_o(next_trim),
    .total_length_o(total), .expired_count_o(expired)
  );

  // Tracker model state.
  logic [7:0]  lifetime;
  logic        ctx_busy [NCTX];
  logic [31:0] ctx_src [NCTX];
  logic [31:0] ctx_dst [NCTX];
  logic [15:0] ctx_id [NCTX];
  logic [7:0]  ctx_proto [NCTX];
  logic [7:0]  ctx_age [NCTX];
  int          seg_cnt [NCTX];
  int          seg_start [NCTX][NSEG];
  int          seg_size [NCTX][NSEG];
  logic        seg_more [NCTX][NSEG];

  request_t pending_reqs[$];
  result_t  expected_results[$];
  int errors = 0;
  int accepted = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int completions = 0;
  bit stim_done = 0;
  bit in_acc = 0;

  // Small key space so that fragments meet their contexts often.
  logic [31:0] key_src [4];
  logic [31:0] key_dst [4];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic result_t track_request(request_t r);
    result_t res;
    int found, c, q, rr, cnt, off, len, ov, trim, tn, nxt;
    int ts[NSEG+1];
    int tz[NSEG+1];
    logic tm[NSEG+1];
    bit contig;
    res = '0;
    found = -1;
    if (r.kind == KIND_TICK || r.kind == KIND_DRAIN) begin
      for (c = 0; c < NCTX; c++) begin
        if (!ctx_busy[c]) continue;
        if (r.kind == KIND_DRAIN) begin
          ctx_busy[c] = 0; seg_cnt[c] = 0; res.expired++;
        end else begin
          ctx_age[c] = ctx_age[c] - 8'd1;
          if (ctx_age[c] == 0) begin
            ctx_busy[c] = 0; seg_cnt[c] = 0; res.expired++;
          end
        end
      end
      res.status = (r.kind == KIND_TICK) ? STAT_TICK : STAT_DRAIN;
      return res;
    end
    for (c = 0; c < NCTX; c++)
      if (found < 0 && ctx_busy[c] && ctx_src[c] == r.src && ctx_dst[c] == r.dst &&
          ctx_id[c] == r.ident && ctx_proto[c] == r.proto) found = c;
    off = int'(r.offset) << 3;
    len = int'(r.len);
    if (!r.mf && r.offset == 0) begin
      res.status = STAT_PASSED;
      if (found >= 0) begin
        ctx_busy[found] = 0; seg_cnt[found] = 0; res.slot = found[2:0];
      end
      return res;
    end
    if (found < 0) begin
      for (c = 0; c < NCTX; c++) if (found < 0 && !ctx_busy[c]) found = c;
      if (found < 0) begin
        res.status = STAT_FULL;
        return res;
      end
      ctx_busy[found] = 1; ctx_src[found] = r.src; ctx_dst[found] = r.dst;
      ctx_id[found] = r.ident; ctx_proto[found] = r.proto;
      ctx_age[found] = lifetime; seg_cnt[found] = 0;
    end
    c = found;
    res.slot = c[2:0];
    cnt = seg_cnt[c];
    for (q = 0; q < cnt; q++) if (seg_start[c][q] > off) break;
    if (q > 0) begin
      ov = seg_start[c][q-1] + seg_size[c][q-1] - off;
      if (ov > 0) begin
        if (ov >= len) begin
          res.status = STAT_COVERED;
          return res;
        end
        off += ov; len -= ov;
      end
    end
    rr = 0; trim = 0;
    for (int i = q; i < cnt; i++) begin
      ov = off + len - seg_start[c][i];
      if (ov <= 0) break;
      if (ov < seg_size[c][i]) begin
        trim = ov;
        break;
      end
      rr++;
    end
    if (cnt - rr >= NSEG) begin
      res.status = STAT_FULL;
      return res;
    end
    if (trim > 0) begin
      seg_start[c][q+rr] += trim;
      seg_size[c][q+rr] -= trim;
    end
    tn = 0;
    for (int k = 0; k < q; k++) begin
      ts[tn] = seg_start[c][k]; tz[tn] = seg_size[c][k]; tm[tn] = seg_more[c][k]; tn++;
    end
    ts[tn] = off; tz[tn] = len; tm[tn] = r.mf; tn++;
    for (int k = q + rr; k < cnt; k++) begin
      ts[tn] = seg_start[c][k]; tz[tn] = seg_size[c][k]; tm[tn] = seg_more[c][k]; tn++;
    end
    for (int k = 0; k < tn; k++) begin
      seg_start[c][k] = ts[k]; seg_size[c][k] = tz[k]; seg_more[c][k] = tm[k];
    end
    seg_cnt[c] = tn;
    res.kept_offset = off[16:0];
    res.kept_length = len[16:0];
    res.removed = rr[4:0];
    res.next_trim = trim[15:0];
    contig = 1; nxt = 0;
    for (int k = 0; k < tn; k++) begin
      if (ts[k] != nxt) begin
        contig = 0;
        break;
      end
      nxt += tz[k];
    end
    if (contig && !tm[tn-1]) begin
      res.status = STAT_COMPLETE;
      res.total = nxt[16:0];
      ctx_busy[c] = 0; seg_cnt[c] = 0;
    end else begin
      res.status = STAT_HELD;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Input acceptance, sampled at the rising edge.
  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && !in_stall;
  end

  // Driver: presents pending requests, changes inputs on the falling edge.
  int drv_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_acc) begin
        // A request of unknown kind changes nothing and yields no result.
        if (cur.kind != KIND_UNKNOWN) expected_results.push_back(track_request(cur));
        accepted++;
        drv_gap = gap_length();
      end
      if (!in_valid || in_acc) begin
        if (drv_gap > 0 || pending_reqs.size() == 0) begin
          if (drv_gap > 0) drv_gap--;
          in_valid <= 1'b0;
        end else begin
          cur <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end
      end
      out_stall <= ($urandom_range(0, 99) < 8) ? 1'b1 :
                   ($urandom_range(0, 99) < 3 ? ($urandom_range(0, 1) == 1) : 1'b0);
    end
  end

  // Monitor: compares accepted results with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", status, -1);
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (status != e.status) report_mismatch("status", status, e.status);
          if (slot != e.slot) report_mismatch("context_slot", slot, e.slot);
          if (kept_off != e.kept_offset) report_mismatch("kept_offset", kept_off, e.kept_offset);
          if (kept_len != e.kept_length) report_mismatch("kept_length", kept_len, e.kept_length);
          if (removed != e.removed) report_mismatch("removed_segments", removed, e.removed);
          if (next_trim != e.next_trim) report_mismatch("next_trim", next_trim, e.next_trim);
          if (total != e.total) report_mismatch("total_length", total, e.total);
          if (expired != e.expired) report_mismatch("expired_count", expired, e.expired);
          if (e.status == STAT_COMPLETE) completions++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic request_t frag_req(int k, logic [15:0] id, int off8, int len, logic mf);
    request_t r;
    r.kind = KIND_DGRAM;
    r.src = key_src[k]; r.dst = key_dst[k]; r.ident = id;
    r.proto = 8'd17 + k[7:0];
    r.offset = off8[12:0]; r.len = len[15:0]; r.mf = mf;
    return r;
  endfunction

  function automatic request_t ctrl_req(kind_e k);
    request_t r;
    r = '{kind: KIND_DGRAM, default: '0};
    r.kind = k;
    r.src = $urandom(); r.dst = $urandom(); r.ident = 16'($urandom());
    return r;
  endfunction

  function automatic request_t noise_req();
    request_t r;
    r.kind = KIND_DGRAM;
    r.src = $urandom(); r.dst = $urandom(); r.ident = 16'($urandom());
    r.proto = 8'($urandom()); r.offset = 13'($urandom()); r.len = 16'($urandom());
    r.mf = 1'($urandom());
    return r;
  endfunction

  // Queues one datagram split into shuffled pieces, possibly overlapping or with one missing.
  task automatic queue_datagram(bit broken);
    int k, nf, unit, off8, span;
    logic [15:0] id;
    request_t pieces[$];
    k = $urandom_range(0, 3);
    id = 16'($urandom_range(0, 7));
    nf = $urandom_range(1, 6);
    unit = $urandom_range(1, 8);
    off8 = 0;
    for (int i = 0; i < nf; i++) begin
      span = unit * 8;
      if ($urandom_range(0, 5) == 0) span += $urandom_range(1, 20);
      pieces.push_back(frag_req(k, id, off8, span, (i != nf - 1)));
      off8 += unit;
    end
    // An extra overlapping piece exercises trimming and removal.
    if ($urandom_range(0, 2) == 0)
      pieces.push_back(frag_req(k, id, $urandom_range(0, off8),
                                $urandom_range(0, unit * 24), 1'b1));
    if (broken && pieces.size() > 1) pieces.delete($urandom_range(0, pieces.size() - 1));
    pieces.shuffle();
    foreach (pieces[i]) pending_reqs.push_back(pieces[i]);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_lifetime(logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    lifetime = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  int phase_life [4] = '{1, 255, 15, 3};
  request_t t;

  initial begin
    rst_n = 0;
    cfg_valid = 0; cfg_data = '0;
    in_valid = 0; out_stall = 0;
    cur = '{kind: KIND_DGRAM, default: '0};
    lifetime = LifetimeReset;
    for (int c = 0; c < NCTX; c++) begin
      ctx_busy[c] = 0; seg_cnt[c] = 0;
    end
    for (int k = 0; k < 4; k++) begin
      key_src[k] = $urandom(); key_dst[k] = $urandom();
    end
    key_src[0] = 32'hFFFF_FFFF; key_dst[0] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed part, at the reset lifetime.
    pending_reqs.push_back(frag_req(0, 16'hFFFF, 0, 0, 1'b0));
    pending_reqs.push_back(frag_req(1, 16'd1, 1, 16, 1'b0));
    pending_reqs.push_back(frag_req(1, 16'd1, 0, 8, 1'b1));
    pending_reqs.push_back(frag_req(1, 16'd1, 0, 8, 1'b1));
    pending_reqs.push_back(frag_req(1, 16'd1, 0, 4, 1'b1));
    pending_reqs.push_back(frag_req(1, 16'd1, 1, 0, 1'b1));
    pending_reqs.push_back(frag_req(1, 16'd1, 0, 24, 1'b1));
    pending_reqs.push_back(frag_req(2, 16'd2, 8191, 65535, 1'b0));
    pending_reqs.push_back(frag_req(2, 16'd2, 0, 0, 1'b0));
    for (int i = 0; i < 9; i++)
      pending_reqs.push_back(frag_req(3, i[15:0], 2, 8, 1'b1));
    t = ctrl_req(KIND_UNKNOWN);
    pending_reqs.push_back(t);
    pending_reqs.push_back(ctrl_req(KIND_TICK));
    pending_reqs.push_back(ctrl_req(KIND_DRAIN));
    // Fill one context's segment store with disjoint pieces.
    for (int i = 0; i < 17; i++)
      pending_reqs.push_back(frag_req(0, 16'h5, 2 * i + 1, 8, 1'b1));
    pending_reqs.push_back(frag_req(0, 16'h5, 0, 300, 1'b1));
    pending_reqs.push_back(ctrl_req(KIND_DRAIN));
    pending_reqs.push_back(noise_req());
    wait_drained();

    // Random phases at several lifetimes, the sender pausing between them.
    for (int p = 0; p < 4; p++) begin
      write_lifetime(phase_life[p][7:0]);
      while (accepted < 60 + (p + 1) * 460) begin
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) queue_datagram(0);
        else if (sel < 78) queue_datagram(1);
        else if (sel < 88) pending_reqs.push_back(ctrl_req(KIND_TICK));
        else if (sel < 90) pending_reqs.push_back(ctrl_req(KIND_DRAIN));
        else if (sel < 92) pending_reqs.push_back(ctrl_req(KIND_UNKNOWN));
        else pending_reqs.push_back(noise_req());
        while (pending_reqs.size() > 8) @(posedge clk);
      end
      wait_drained();
    end

    $display("Checked %0d requests and %0d results, %0d datagrams reassembled,",
             accepted, results_seen, completions);
    $display("over four lifetime settings including 1 and 255.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
